/* hdl/tch_pkg.sv */
// ----------------------------------------------------------------------------
// Tilt-compensated heading package
// Widths, fixed-point constants, payload types and the arctangent table.
// ----------------------------------------------------------------------------
package tch_pkg;

	localparam int SAMPLE_WIDTH  = 16;
	localparam int CORDIC_STAGES = 16;
	localparam int TAB_LEN       = 24;
	localparam int NST           = (CORDIC_STAGES < TAB_LEN) ? CORDIC_STAGES : TAB_LEN;

	localparam int SQ_W    = 2 * SAMPLE_WIDTH;
	localparam int RAD_W   = SQ_W + 16;
	localparam int ROOT_W  = SAMPLE_WIDTH + 8;
	localparam int VEC_W   = SAMPLE_WIDTH + 16;
	localparam int CRD_W   = VEC_W + 20;
	localparam int ANG_W   = 18;
	localparam int TRIG_W  = 16;
	localparam int SC_W    = 34;
	localparam int PROD_W  = 2 * TRIG_W;
	localparam int SRT_W   = 18;
	localparam int MT_W    = SAMPLE_WIDTH + TRIG_W;
	localparam int MS_W    = SAMPLE_WIDTH + SRT_W;
	localparam int SUM_W   = SAMPLE_WIDTH + 20;
	localparam int MUL_W   = 25;
	localparam int HDM_W   = ANG_W + MUL_W;
	localparam int CD_W    = 18;
	localparam int HEAD_W  = 16;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
	typedef logic signed [VEC_W-1:0]        vec_t;
	typedef logic signed [CRD_W-1:0]        crd_t;
	typedef logic signed [ANG_W-1:0]        ang_t;
	typedef logic signed [TRIG_W-1:0]       trig_t;
	typedef logic signed [SC_W-1:0]         sc_t;
	typedef logic signed [PROD_W-1:0]       prod_t;
	typedef logic signed [SRT_W-1:0]        srt_t;
	typedef logic signed [MT_W-1:0]         mt_t;
	typedef logic signed [MS_W-1:0]         ms_t;
	typedef logic signed [SUM_W-1:0]        sum_t;
	typedef logic signed [HDM_W-1:0]        hdm_t;
	typedef logic signed [CD_W-1:0]         cd_t;
	typedef logic [HEAD_W-1:0]              heading_t;

	typedef struct packed {
		sample_t x;
		sample_t y;
		sample_t z;
	} axes_t;

	typedef struct packed {
		axes_t           accel;
		axes_t           mag;
		logic [SQ_W-1:0] sq;
	} item_t;

	localparam ang_t                    ANG_PI       = ANG_W'(51472);
	localparam ang_t                    ANG_HALF_PI  = ANG_W'(25736);
	localparam sc_t                     INV_GAIN     = SC_W'(652032874);
	localparam logic signed [MUL_W-1:0] CENTIDEG_MUL = MUL_W'(5867088);
	localparam cd_t                     HEAD_FULL    = CD_W'(36000);

	function automatic ang_t tab_atan(input int idx);
		ang_t v;
		case (idx)
			0:       v = ANG_W'(12868);
			1:       v = ANG_W'(7596);
			2:       v = ANG_W'(4014);
			3:       v = ANG_W'(2037);
			4:       v = ANG_W'(1023);
			5:       v = ANG_W'(512);
			6:       v = ANG_W'(256);
			7:       v = ANG_W'(128);
			8:       v = ANG_W'(64);
			9:       v = ANG_W'(32);
			10:      v = ANG_W'(16);
			11:      v = ANG_W'(8);
			12:      v = ANG_W'(4);
			13:      v = ANG_W'(2);
			14:      v = ANG_W'(1);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

/* hdl/tch_in_if.sv */
// ----------------------------------------------------------------------------
// Sample channel
// One request carries the three accelerometer and three magnetometer axes.
// ----------------------------------------------------------------------------
interface tch_in_if import tch_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t accel_x;
	sample_t accel_y;
	sample_t accel_z;
	sample_t mag_x;
	sample_t mag_y;
	sample_t mag_z;

	modport source (output valid, output accel_x, output accel_y, output accel_z,
		output mag_x, output mag_y, output mag_z, input ready);
	modport sink (input valid, input accel_x, input accel_y, input accel_z,
		input mag_x, input mag_y, input mag_z, output ready);
endinterface

/* hdl/tch_out_if.sv */
// ----------------------------------------------------------------------------
// Heading channel
// One request carries one heading in hundredths of a degree.
// ----------------------------------------------------------------------------
interface tch_out_if import tch_pkg::*; ();
	logic     valid;
	logic     ready;
	heading_t heading_centideg;

	modport source (output valid, output heading_centideg, input ready);
	modport sink (input valid, input heading_centideg, output ready);
endinterface

/* hdl/tch_front.sv */
// ----------------------------------------------------------------------------
// Front end
// Accepts samples, forms the squared accelerometer magnitude in the y-z plane
// and holds the requests in a short queue for the back end.
// ----------------------------------------------------------------------------
module tch_front import tch_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	tch_in_if.sink   sample,
	input  logic     pop,
	output logic     avail,
	output item_t    item
);

	item_t               mem [0:QUEUE_DEPTH-1];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic signed [SQ_W-1:0] ysq;
	logic signed [SQ_W-1:0] zsq;
	item_t               wr_item;
	logic                push;
	logic                take;

	always_comb begin
		wr_item.accel.x = sample.accel_x;
		wr_item.accel.y = sample.accel_y;
		wr_item.accel.z = sample.accel_z;
		wr_item.mag.x   = sample.mag_x;
		wr_item.mag.y   = sample.mag_y;
		wr_item.mag.z   = sample.mag_z;
		ysq             = sample.accel_y * sample.accel_y;
		zsq             = sample.accel_z * sample.accel_z;
		wr_item.sq      = $unsigned(ysq) + $unsigned(zsq);
	end

	assign sample.ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign avail        = (count_q != '0);
	assign push         = sample.valid && sample.ready;
	assign take         = pop && avail;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (take) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + QCNT_W'(push) - QCNT_W'(take);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wr_item;
		end
		if (take) begin
			item <= mem[rd_ptr_q];
		end
	end

endmodule

/* hdl/tch_isqrt.sv */
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Floor square root, one result bit per stage.
// ----------------------------------------------------------------------------
module tch_isqrt import tch_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic [RAD_W-1:0]  rad,
	output logic [ROOT_W-1:0] root
);

	logic [RAD_W-1:0] rem_s [0:ROOT_W-1];
	logic [RAD_W-1:0] res_s [0:ROOT_W-1];

	for (genvar k = 0; k < ROOT_W; k++) begin : g_step
		localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (2 * (ROOT_W - 1 - k));
		logic [RAD_W-1:0] rem_in;
		logic [RAD_W-1:0] res_in;
		logic [RAD_W-1:0] trial;

		if (k == 0) begin : g_first
			assign rem_in = rad;
			assign res_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign res_in = res_s[k-1];
		end

		assign trial = res_in + BIT;

		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_in >= trial) begin
					rem_s[k] <= rem_in - trial;
					res_s[k] <= (res_in >> 1) + BIT;
				end else begin
					rem_s[k] <= rem_in;
					res_s[k] <= res_in >> 1;
				end
			end
		end
	end

	assign root = res_s[ROOT_W-1][ROOT_W-1:0];

endmodule

/* hdl/tch_atan2.sv */
// ----------------------------------------------------------------------------
// Pipelined vectoring CORDIC
// Gives atan2(y, x) as a Q2.14 angle; a zero vector gives angle zero.
// ----------------------------------------------------------------------------
module tch_atan2 import tch_pkg::*; (
	input  logic clk,
	input  logic en,
	input  vec_t y_in,
	input  vec_t x_in,
	output ang_t angle
);

	crd_t x_s    [0:NST];
	crd_t y_s    [0:NST];
	ang_t z_s    [0:NST];
	logic zero_s [0:NST];
	crd_t xw;
	crd_t yw;

	assign xw = crd_t'(x_in) <<< 16;
	assign yw = crd_t'(y_in) <<< 16;

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s[0] <= (x_in == '0) && (y_in == '0);
			if (xw[CRD_W-1]) begin
				if (!yw[CRD_W-1]) begin
					x_s[0] <= yw;
					y_s[0] <= -xw;
					z_s[0] <= ANG_HALF_PI;
				end else begin
					x_s[0] <= -yw;
					y_s[0] <= xw;
					z_s[0] <= -ANG_HALF_PI;
				end
			end else begin
				x_s[0] <= xw;
				y_s[0] <= yw;
				z_s[0] <= '0;
			end
		end
	end

	for (genvar k = 0; k < NST; k++) begin : g_stage
		localparam ang_t ATAN = tab_atan(k);

		always_ff @(posedge clk) begin
			if (en) begin
				zero_s[k+1] <= zero_s[k];
				if (!y_s[k][CRD_W-1]) begin
					x_s[k+1] <= x_s[k] + (y_s[k] >>> k);
					y_s[k+1] <= y_s[k] - (x_s[k] >>> k);
					z_s[k+1] <= z_s[k] + ATAN;
				end else begin
					x_s[k+1] <= x_s[k] - (y_s[k] >>> k);
					y_s[k+1] <= y_s[k] + (x_s[k] >>> k);
					z_s[k+1] <= z_s[k] - ATAN;
				end
			end
		end
	end

	assign angle = zero_s[NST] ? '0 : z_s[NST];

endmodule

/* hdl/tch_sincos.sv */
// ----------------------------------------------------------------------------
// Pipelined rotation CORDIC
// Gives the sine and cosine of a Q2.14 angle with 14 fractional bits.
// ----------------------------------------------------------------------------
module tch_sincos import tch_pkg::*; (
	input  logic  clk,
	input  logic  en,
	input  ang_t  angle,
	output trig_t sin_v,
	output trig_t cos_v
);

	sc_t  x_s   [0:NST];
	sc_t  y_s   [0:NST];
	ang_t a_s   [0:NST];
	logic neg_s [0:NST];
	sc_t  xf;
	sc_t  yf;
	sc_t  xr;
	sc_t  yr;

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= INV_GAIN;
			y_s[0] <= '0;
			if (angle > ANG_HALF_PI) begin
				a_s[0]   <= angle - ANG_PI;
				neg_s[0] <= 1'b1;
			end else if (angle < -ANG_HALF_PI) begin
				a_s[0]   <= angle + ANG_PI;
				neg_s[0] <= 1'b1;
			end else begin
				a_s[0]   <= angle;
				neg_s[0] <= 1'b0;
			end
		end
	end

	for (genvar k = 0; k < NST; k++) begin : g_stage
		localparam ang_t ATAN = tab_atan(k);

		always_ff @(posedge clk) begin
			if (en) begin
				neg_s[k+1] <= neg_s[k];
				if (!a_s[k][ANG_W-1]) begin
					x_s[k+1] <= x_s[k] - (y_s[k] >>> k);
					y_s[k+1] <= y_s[k] + (x_s[k] >>> k);
					a_s[k+1] <= a_s[k] - ATAN;
				end else begin
					x_s[k+1] <= x_s[k] + (y_s[k] >>> k);
					y_s[k+1] <= y_s[k] - (x_s[k] >>> k);
					a_s[k+1] <= a_s[k] + ATAN;
				end
			end
		end
	end

	always_comb begin
		xf    = neg_s[NST] ? -x_s[NST] : x_s[NST];
		yf    = neg_s[NST] ? -y_s[NST] : y_s[NST];
		xr    = xf + SC_W'(32768);
		yr    = yf + SC_W'(32768);
		cos_v = trig_t'(xr >>> 16);
		sin_v = trig_t'(yr >>> 16);
	end

endmodule

/* hdl/tch_back.sv */
// ----------------------------------------------------------------------------
// Back end
// Computes pitch and roll, rotates the magnetic vector into the horizontal
// plane and converts the heading angle to hundredths of a degree.
// ----------------------------------------------------------------------------
module tch_back import tch_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       avail,
	input  item_t      item,
	output logic       en,
	tch_out_if.source  heading
);

	localparam int LA = NST + 1;
	localparam int T  = ROOT_W + 2 * LA;
	localparam int VL = ROOT_W + 3 * LA + 7;

	logic [VL-1:0]     vld_q;
	logic [RAD_W-1:0]  rad;
	logic [ROOT_W-1:0] root;
	axes_t             acc_d [1:ROOT_W];
	axes_t             mag_d [1:T];
	ang_t              roll_ang;
	ang_t              pitch_ang;
	ang_t              hd_ang;
	trig_t             sp;
	trig_t             cp;
	trig_t             sr;
	trig_t             cr;
	vec_t              roll_y;
	vec_t              roll_x;
	vec_t              pitch_y;
	vec_t              pitch_x;

	prod_t   psp_s1;
	prod_t   pcp_s1;
	mt_t     mxcp_s1;
	mt_t     mzsp_s1;
	mt_t     mycr_s1;
	sample_t mx_s1;
	sample_t mz_s1;
	srt_t    srsp_s2;
	srt_t    srcp_s2;
	vec_t    xh_s2;
	mt_t     mycr_s2;
	sample_t mx_s2;
	sample_t mz_s2;
	ms_t     mxsr_s3;
	ms_t     mzsr_s3;
	vec_t    xh_s3;
	mt_t     mycr_s3;
	vec_t    yh_s4;
	vec_t    nxh_s4;
	hdm_t    hmul_s5;
	heading_t heading_q;

	prod_t   psp_r;
	prod_t   pcp_r;
	sum_t    xh_w;
	sum_t    yh_w;
	hdm_t    hround;
	cd_t     cd;
	cd_t     cd_pos;
	cd_t     cd_fin;

	assign en = !vld_q[VL-1] || heading.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[VL-2:0], avail};
		end
	end

	assign rad = {item.sq, 16'b0};

	tch_isqrt u_sqrt (
		.clk  (clk),
		.en   (en),
		.rad  (rad),
		.root (root)
	);

	for (genvar k = 1; k <= ROOT_W; k++) begin : g_acc
		always_ff @(posedge clk) begin
			if (en) begin
				acc_d[k] <= (k == 1) ? item.accel : acc_d[(k == 1) ? 1 : k - 1];
			end
		end
	end

	for (genvar k = 1; k <= T; k++) begin : g_mag
		always_ff @(posedge clk) begin
			if (en) begin
				mag_d[k] <= (k == 1) ? item.mag : mag_d[(k == 1) ? 1 : k - 1];
			end
		end
	end

	assign roll_y  = vec_t'(acc_d[ROOT_W].y);
	assign roll_x  = vec_t'(acc_d[ROOT_W].z);
	assign pitch_y = -(vec_t'(acc_d[ROOT_W].x) <<< 8);
	assign pitch_x = vec_t'(root);

	tch_atan2 u_roll (
		.clk   (clk),
		.en    (en),
		.y_in  (roll_y),
		.x_in  (roll_x),
		.angle (roll_ang)
	);

	tch_atan2 u_pitch (
		.clk   (clk),
		.en    (en),
		.y_in  (pitch_y),
		.x_in  (pitch_x),
		.angle (pitch_ang)
	);

	tch_sincos u_pitch_trig (
		.clk   (clk),
		.en    (en),
		.angle (pitch_ang),
		.sin_v (sp),
		.cos_v (cp)
	);

	tch_sincos u_roll_trig (
		.clk   (clk),
		.en    (en),
		.angle (roll_ang),
		.sin_v (sr),
		.cos_v (cr)
	);

	always_comb begin
		psp_r  = psp_s1 + PROD_W'(8192);
		pcp_r  = pcp_s1 + PROD_W'(8192);
		xh_w   = sum_t'(mxcp_s1) + sum_t'(mzsp_s1);
		yh_w   = sum_t'(mxsr_s3) + sum_t'(mycr_s3) - sum_t'(mzsr_s3);
		hround = hmul_s5 + HDM_W'(8388608);
		cd     = cd_t'(hround >>> 24);
		cd_pos = cd[CD_W-1] ? cd + HEAD_FULL : cd;
		cd_fin = (cd_pos >= HEAD_FULL) ? cd_pos - HEAD_FULL : cd_pos;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			psp_s1    <= sr * sp;
			pcp_s1    <= sr * cp;
			mxcp_s1   <= mag_d[T].x * cp;
			mzsp_s1   <= mag_d[T].z * sp;
			mycr_s1   <= mag_d[T].y * cr;
			mx_s1     <= mag_d[T].x;
			mz_s1     <= mag_d[T].z;

			srsp_s2   <= srt_t'(psp_r >>> 14);
			srcp_s2   <= srt_t'(pcp_r >>> 14);
			xh_s2     <= vec_t'(xh_w);
			mycr_s2   <= mycr_s1;
			mx_s2     <= mx_s1;
			mz_s2     <= mz_s1;

			mxsr_s3   <= mx_s2 * srsp_s2;
			mzsr_s3   <= mz_s2 * srcp_s2;
			xh_s3     <= xh_s2;
			mycr_s3   <= mycr_s2;

			yh_s4     <= vec_t'(yh_w);
			nxh_s4    <= -xh_s3;

			hmul_s5   <= hd_ang * CENTIDEG_MUL;

			heading_q <= HEAD_W'(cd_fin);
		end
	end

	tch_atan2 u_heading (
		.clk   (clk),
		.en    (en),
		.y_in  (nxh_s4),
		.x_in  (yh_s4),
		.angle (hd_ang)
	);

	assign heading.valid            = vld_q[VL-1];
	assign heading.heading_centideg = heading_q;

endmodule

/* hdl/tilt_compensated_heading_top.sv */
// ----------------------------------------------------------------------------
// Tilt-compensated compass heading
// The sample channel takes one request per sensor sample: three signed
// accelerometer axes and three signed magnetometer axes. The heading channel
// gives one request per sample, the heading in hundredths of a degree from 0
// to 35999, in the order the samples came in.
// A new sample is taken in every cycle while the queue has room. A sample
// goes from acceptance to a valid heading through the queue read, the
// pipelined square root, the three CORDIC passes (pitch and roll, their
// sines and cosines, and the heading angle) and the registered products.
// A four-entry queue sits behind the sample channel. When the receiver holds
// ready low, the back-end pipeline freezes with the finished heading on the
// output register, the queue fills, and only then does the sample channel
// drop ready. Reset empties the queue and clears every valid flag; nothing
// else needs clearing.
// ----------------------------------------------------------------------------
module tilt_compensated_heading_top import tch_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	tch_in_if.sink    sample,
	tch_out_if.source heading
);

	logic  en;
	logic  avail;
	item_t item;

	tch_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample),
		.pop    (en),
		.avail  (avail),
		.item   (item)
	);

	tch_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.avail   (avail),
		.item    (item),
		.en      (en),
		.heading (heading)
	);

endmodule

/* hdl/tch_checker.sv */
// ----------------------------------------------------------------------------
// Heading port checker
// Watches the top-level channels for stall behaviour and result range.
// ----------------------------------------------------------------------------
module tch_checker import tch_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     in_ready,
	input logic     out_valid,
	input logic     out_ready,
	input heading_t heading_centideg
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(heading_centideg))
		else $error("Heading request changed while stalled.");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> heading_centideg < HEAD_W'(36000))
		else $error("Heading outside 0 to 35999.");

	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> $past(out_valid && !out_ready))
		else $error("Sample channel stalled without a stalled heading.");

endmodule

bind tilt_compensated_heading_top tch_checker u_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_ready         (sample.ready),
	.out_valid        (heading.valid),
	.out_ready        (heading.ready),
	.heading_centideg (heading.heading_centideg)
);

/* tb/sv/tch_tb_if.sv */
// ----------------------------------------------------------------------------
// Testbench channel helpers
// Holds no interface of its own: the sample and heading channels come from
// the design. This file carries the shared request type used by the bench.
// ----------------------------------------------------------------------------
package tch_tb_pkg;
	import tch_pkg::*;

	typedef struct packed {
		sample_t ax;
		sample_t ay;
		sample_t az;
		sample_t mx;
		sample_t my;
		sample_t mz;
	} sample_req_t;

endpackage

/* tb/sv/tch_heading_checker.sv */
// ----------------------------------------------------------------------------
// Heading checker
// Watches both channels, works out the heading of every accepted sample with
// its own fixed-point CORDIC arithmetic and compares it with the heading that
// comes out, in order.
// ----------------------------------------------------------------------------
module tch_heading_checker import tch_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	tch_in_if.sink    sample,
	tch_out_if.sink   heading,
	input  logic      sample_ready,
	input  logic      heading_ready,
	output int        fail_count,
	output int        pending
);

	localparam longint PI_Q14   = 51472;
	localparam longint HPI_Q14  = 25736;
	localparam longint GAIN_Q30 = 652032874;
	localparam longint DEG_MUL  = 5867088;

	heading_t expected_headings[$];

	function automatic longint atan_q14(input int idx);
		longint t[15] = '{12868, 7596, 4014, 2037, 1023, 512, 256, 128,
			64, 32, 16, 8, 4, 2, 1};
		if (idx < 15)
			return t[idx];
		return 0;
	endfunction

	function automatic longint int_sqrt(input longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return longint'(r);
	endfunction

	function automatic longint angle_of(input longint y, input longint x);
		longint z;
		longint t;
		longint xs;
		longint ys;
		z = 0;
		if (x == 0 && y == 0)
			return 0;
		x = x * 65536;
		y = y * 65536;
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y;
				y = -t;
				z = HPI_Q14;
			end else begin
				x = -y;
				y = t;
				z = -HPI_Q14;
			end
		end
		for (int i = 0; i < CORDIC_STAGES && i < TAB_LEN; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x += ys;
				y -= xs;
				z += atan_q14(i);
			end else begin
				x -= ys;
				y += xs;
				z -= atan_q14(i);
			end
		end
		return z;
	endfunction

	function automatic longint round_q(input longint v, input int frac);
		return (v + (64'sd1 <<< (frac - 1))) >>> frac;
	endfunction

	task automatic sin_cos(input longint a, output longint s, output longint c);
		longint x;
		longint y;
		longint xs;
		longint ys;
		bit flip;
		x = GAIN_Q30;
		y = 0;
		flip = 0;
		if (a > HPI_Q14) begin
			a -= PI_Q14;
			flip = 1;
		end else if (a < -HPI_Q14) begin
			a += PI_Q14;
			flip = 1;
		end
		for (int i = 0; i < CORDIC_STAGES && i < TAB_LEN; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (a >= 0) begin
				x -= ys;
				y += xs;
				a -= atan_q14(i);
			end else begin
				x += ys;
				y -= xs;
				a += atan_q14(i);
			end
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		c = round_q(x, 16);
		s = round_q(y, 16);
	endtask

	task automatic predict_heading(input longint ax, input longint ay,
			input longint az, input longint mx, input longint my,
			input longint mz, output heading_t h);
		longint root;
		longint roll;
		longint pitch;
		longint sp;
		longint cp;
		longint sr;
		longint cr;
		longint srsp;
		longint srcp;
		longint xh;
		longint yh;
		longint cd;
		root = int_sqrt(longint'(ay * ay + az * az) << 16);
		roll = angle_of(ay, az);
		pitch = angle_of(-ax * 256, root);
		sin_cos(pitch, sp, cp);
		sin_cos(roll, sr, cr);
		srsp = round_q(sr * sp, 14);
		srcp = round_q(sr * cp, 14);
		xh = mx * cp + mz * sp;
		yh = mx * srsp + my * cr - mz * srcp;
		cd = (angle_of(-xh, yh) * DEG_MUL + (64'sd1 <<< 23)) >>> 24;
		if (cd < 0)
			cd += 36000;
		if (cd >= 36000)
			cd -= 36000;
		h = heading_t'(cd);
	endtask

	assign pending = expected_headings.size();

	always @(posedge clk or negedge arst_n) begin
		heading_t h;
		heading_t want;
		if (!arst_n) begin
			fail_count <= 0;
		end else begin
			if (sample.valid && sample_ready) begin
				predict_heading(sample.accel_x, sample.accel_y, sample.accel_z,
					sample.mag_x, sample.mag_y, sample.mag_z, h);
				expected_headings.push_back(h);
			end
			if (heading.valid && heading_ready) begin
				if (expected_headings.size() == 0) begin
					if (fail_count < 10)
						$display("Heading %0d arrived with no sample waiting",
							heading.heading_centideg);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_headings.pop_front();
					if (heading.heading_centideg !== want) begin
						if (fail_count < 10)
							$display("Heading mismatch: expected %0d, got %0d",
								want, heading.heading_centideg);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

/* tb/sv/tilt_compensated_heading_top_tb.sv */
// ----------------------------------------------------------------------------
// Tilt-compensated heading testbench
// Drives directed and random sensor samples under varying sender and receiver
// idling; a checker beside the block predicts every heading and counts
// mismatches, and this module gives the verdict.
// ----------------------------------------------------------------------------
module tilt_compensated_heading_top_tb;
	import tch_pkg::*;
	import tch_tb_pkg::*;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   send_idle;
	int   recv_idle;

	tch_in_if  sample();
	tch_out_if heading();

	tilt_compensated_heading_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample.sink),
		.heading(heading.source)
	);

	tch_heading_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample       (sample.sink),
		.heading      (heading.sink),
		.sample_ready (sample.ready),
		.heading_ready(heading.ready),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	initial begin
		#4000000;
		$display("Simulation FAILED");
		$finish;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heading.ready <= 1'b0;
		end else begin
			heading.ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	function automatic sample_t pick_axis();
		case ($urandom_range(7))
			0:       return sample_t'(-32768);
			1:       return sample_t'(32767);
			2:       return '0;
			3:       return sample_t'(int'($urandom_range(64)) - 32);
			default: return sample_t'($urandom);
		endcase
	endfunction

	task automatic send_sample(input sample_req_t s);
		while ($urandom_range(99) < send_idle) begin
			sample.valid <= 1'b0;
			@(posedge clk);
		end
		sample.valid   <= 1'b1;
		sample.accel_x <= s.ax;
		sample.accel_y <= s.ay;
		sample.accel_z <= s.az;
		sample.mag_x   <= s.mx;
		sample.mag_y   <= s.my;
		sample.mag_z   <= s.mz;
		@(posedge clk);
		while (!sample.ready)
			@(posedge clk);
	endtask

	task automatic drain();
		sample.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	initial begin
		sample_req_t s;
		sample_req_t edge_set[$];
		int          phase_items;
		sample.valid   = 1'b0;
		sample.accel_x = '0;
		sample.accel_y = '0;
		sample.accel_z = '0;
		sample.mag_x   = '0;
		sample.mag_y   = '0;
		sample.mag_z   = '0;
		send_idle      = 27;
		recv_idle      = 85;
		arst_n         = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Level, zero vectors, negative axes with zero partner, and extremes.
		edge_set.push_back('{0, 0, 0, 0, 0, 0});
		edge_set.push_back('{0, 0, 1000, 1000, 0, 0});
		edge_set.push_back('{0, 0, 1000, -1000, 0, 0});
		edge_set.push_back('{0, 0, 1000, 0, 1000, 0});
		edge_set.push_back('{0, 0, 1000, 0, -1000, 0});
		edge_set.push_back('{0, 0, -1000, 500, 0, 0});
		edge_set.push_back('{0, 0, 1000, -1000, 0, 500});
		edge_set.push_back('{0, -1000, 0, 300, 200, 100});
		edge_set.push_back('{1000, 0, 0, 300, 200, 100});
		edge_set.push_back('{-1000, 0, 0, 300, 200, 100});
		edge_set.push_back('{-32768, -32768, -32768, -32768, -32768, -32768});
		edge_set.push_back('{32767, 32767, 32767, 32767, 32767, 32767});
		edge_set.push_back('{-32768, 32767, -32768, 32767, -32768, 32767});
		edge_set.push_back('{32767, -32768, 32767, -32768, 32767, -32768});
		edge_set.push_back('{0, -32768, 0, 0, 0, -32768});
		edge_set.push_back('{16384, 0, 16384, 1000, 1, 1000});
		edge_set.push_back('{-21845, -21845, 21845, -21845, 21845, 21845});
		edge_set.push_back('{1, 1, 1, 1, 1, 1});
		edge_set.push_back('{-1, -1, -1, -1, -1, -1});
		edge_set.push_back('{0, 0, 1000, -1000, 1, 0});
		foreach (edge_set[i])
			send_sample(edge_set[i]);
		drain();

		for (int phase = 0; phase < 3; phase++) begin
			send_idle   = (phase == 0) ? 27 : (phase == 1) ? 85 : 0;
			recv_idle   = (phase == 0) ? 85 : (phase == 1) ? 27 : 0;
			phase_items = 0;
			while (phase_items < 300) begin
				s = '{pick_axis(), pick_axis(), pick_axis(),
					pick_axis(), pick_axis(), pick_axis()};
				send_sample(s);
				phase_items++;
				if (phase_items == 150 && phase == 2)
					drain();
			end
			drain();
		end

		repeat (200) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

/* tilt_compensated_heading_top.f */
hdl/tch_pkg.sv
hdl/tch_in_if.sv
hdl/tch_out_if.sv
hdl/tch_front.sv
hdl/tch_isqrt.sv
hdl/tch_atan2.sv
hdl/tch_sincos.sv
hdl/tch_back.sv
hdl/tilt_compensated_heading_top.sv
hdl/tch_checker.sv
tb/sv/tch_tb_if.sv
tb/sv/tch_heading_checker.sv
tb/sv/tilt_compensated_heading_top_tb.sv
